/* design/oltm_pkg.sv */
package oltm_pkg;

  localparam int MAX_LEN_DEF      = 4096;
  localparam int TARGET_BYTES_DEF = 16;

  localparam int CH_W           = 8;
  localparam int KIND_W         = 2;
  localparam int OPTION_START_W = 12;
  localparam int NAME_LENGTH_W  = 13;
  localparam int VALUE_LENGTH_W = 12;
  localparam int TLEN_W         = 5;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;
  localparam int BYTES_PER_WORD = CFG_DATA_W / CH_W;

  localparam logic [CH_W-1:0] QUOTE_CH  = 8'h22;
  localparam logic [CH_W-1:0] EQUALS_CH = 8'h3D;
  localparam logic [CH_W-1:0] COMMA_CH  = 8'h2C;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEN  = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_OPTION = 2'd0,
    KIND_END    = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            final_byte;
  } in_item_t;

  typedef struct packed {
    kind_e                     kind;
    logic [OPTION_START_W-1:0] option_start;
    logic [NAME_LENGTH_W-1:0]  name_length;
    logic                      has_value;
    logic [VALUE_LENGTH_W-1:0] value_length;
    logic                      name_match;
    logic                      is_last;
  } result_t;

endpackage

/* design/oltm_in_reg.sv */
module oltm_in_reg
  import oltm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t item_i,
  output logic     valid_o,
  output in_item_t item_o,
  input  logic     take_i
);

  logic     valid_q;
  in_item_t item_q;

  // free when empty or when the held transaction moves on this cycle
  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

/* design/oltm_name_cmp.sv */
module oltm_name_cmp
  import oltm_pkg::*;
#(
  parameter int TARGET_BYTES = TARGET_BYTES_DEF,
  parameter int POS_W        = 13
) (
  input  logic [CH_W-1:0]                    ch_i,
  input  logic [POS_W-1:0]                   idx_i,
  input  logic [TARGET_BYTES-1:0][CH_W-1:0]  target_i,
  input  logic [TLEN_W-1:0]                  tlen_i,
  output logic                               mismatch_o
);

  localparam int SEL_W = (TARGET_BYTES > 1) ? $clog2(TARGET_BYTES) : 1;

  logic             beyond;
  logic [SEL_W-1:0] sel;

  assign sel    = idx_i[SEL_W-1:0];
  assign beyond = (idx_i >= POS_W'(TARGET_BYTES)) || (idx_i >= POS_W'(tlen_i));

  // a selected byte past the stored ones is already covered by beyond
  assign mismatch_o = beyond || (target_i[sel] != ch_i);

endmodule

/* design/oltm_core.sv */
module oltm_core
  import oltm_pkg::*;
#(
  parameter int MAX_LEN      = MAX_LEN_DEF,
  parameter int TARGET_BYTES = TARGET_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  in_item_t                          item_i,
  output logic                              take_o,
  input  logic [TARGET_BYTES-1:0][CH_W-1:0] target_i,
  input  logic [TLEN_W-1:0]                 tlen_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output result_t                           result_o
);

  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam int OFF_W = $clog2(MAX_LEN);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [OFF_W-1:0] start_q, start_d;
  logic [OFF_W-1:0] sep_off_q, sep_off_d;
  logic             open_q, open_d;
  logic             quote_q, quote_d;
  logic             sep_q, sep_d;
  logic             mism_q, mism_d;
  logic             skip_q, skip_d;
  logic             out_v_q, out_v_d;
  result_t          res_q, res_d;

  logic [OFF_W-1:0] start_eff;
  logic [POS_W-1:0] start_ext, sep_ext, pos_inc, stop, idx, nlen, vlen;
  logic             sep_eff, mism_eff, quote_n, is_comma, is_sep, sep_now;
  logic             last, nm, mism_new, emit, clear;

  assign take_o = in_valid_i && (!out_v_q || out_ready_i);
  assign last   = item_i.final_byte;

  oltm_name_cmp #(
    .TARGET_BYTES(TARGET_BYTES),
    .POS_W       (POS_W)
  ) u_name_cmp (
    .ch_i      (item_i.ch),
    .idx_i     (idx),
    .target_i  (target_i),
    .tlen_i    (tlen_i),
    .mismatch_o(nm)
  );

  always_comb begin
    // a closed option restarts at the current byte
    start_eff = open_q ? start_q : pos_q[OFF_W-1:0];
    start_ext = POS_W'(start_eff);
    sep_eff   = open_q && sep_q;
    mism_eff  = open_q && mism_q;
    quote_n   = (open_q && quote_q) ^ (item_i.ch == QUOTE_CH);
    is_comma  = (item_i.ch == COMMA_CH);
    is_sep    = !sep_eff && (item_i.ch == EQUALS_CH);
    sep_now   = sep_eff || is_sep;
    pos_inc   = pos_q + POS_W'(1);
    idx       = pos_q - start_ext;
    sep_ext   = is_sep ? pos_q : POS_W'(sep_off_q);
    stop      = is_comma ? pos_q : pos_inc;
    nlen      = sep_now ? (sep_ext - start_ext) : (stop - start_ext);
    vlen      = sep_now ? (stop - sep_ext - POS_W'(1)) : '0;
    mism_new  = mism_eff || (!sep_eff && !is_sep && !is_comma && nm);

    pos_d     = pos_q;
    start_d   = start_q;
    sep_off_d = sep_off_q;
    open_d    = open_q;
    quote_d   = quote_q;
    sep_d     = sep_q;
    mism_d    = mism_q;
    skip_d    = skip_q;
    emit      = 1'b0;
    clear     = 1'b0;
    res_d     = '0;
    res_d.kind    = KIND_OPTION;
    res_d.is_last = last;

    if (take_o) begin
      if (skip_q) begin
        if (last) begin
          emit       = 1'b1;
          res_d.kind = KIND_ERROR;
          clear      = 1'b1;
        end
      end else if (pos_q >= POS_W'(MAX_LEN)) begin
        emit       = 1'b1;
        res_d.kind = KIND_ERROR;
        clear      = last;
        skip_d     = !last;
      end else if (quote_n) begin
        open_d  = 1'b1;
        start_d = start_eff;
        sep_d   = sep_eff;
        quote_d = 1'b1;
        mism_d  = mism_eff || (!sep_eff && nm);
        pos_d   = pos_inc;
        if (last) begin
          // open quote at the end: drop the option
          emit       = 1'b1;
          res_d.kind = KIND_END;
          clear      = 1'b1;
        end
      end else if (is_comma && (pos_q == start_ext)) begin
        emit       = 1'b1;
        res_d.kind = KIND_ERROR;
        clear      = last;
        skip_d     = !last;
      end else begin
        open_d  = 1'b1;
        start_d = start_eff;
        quote_d = 1'b0;
        sep_d   = sep_now;
        mism_d  = mism_new;
        pos_d   = pos_inc;
        if (is_sep) begin
          sep_off_d = pos_q[OFF_W-1:0];
        end
        if (is_comma || last) begin
          emit               = 1'b1;
          res_d.option_start = OPTION_START_W'(start_eff);
          res_d.name_length  = NAME_LENGTH_W'(nlen);
          res_d.has_value    = sep_now;
          res_d.value_length = VALUE_LENGTH_W'(vlen);
          res_d.name_match   = !mism_new && (nlen == POS_W'(tlen_i));
          open_d             = 1'b0;
          sep_d              = 1'b0;
          mism_d             = 1'b0;
          clear              = last;
        end
      end
    end

    if (clear) begin
      pos_d     = '0;
      start_d   = '0;
      sep_off_d = '0;
      open_d    = 1'b0;
      quote_d   = 1'b0;
      sep_d     = 1'b0;
      mism_d    = 1'b0;
      skip_d    = 1'b0;
    end

    if (take_o) begin
      out_v_d = emit;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end else begin
      out_v_d = out_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      start_q   <= '0;
      sep_off_q <= '0;
      open_q    <= 1'b0;
      quote_q   <= 1'b0;
      sep_q     <= 1'b0;
      mism_q    <= 1'b0;
      skip_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      start_q   <= start_d;
      sep_off_q <= sep_off_d;
      open_q    <= open_d;
      quote_q   <= quote_d;
      sep_q     <= sep_d;
      mism_q    <= mism_d;
      skip_q    <= skip_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign result_o    = res_q;

endmodule

/* design/option_list_tokenizer_matcher_top.sv */
// Option list tokenizer and name matcher.
// Input channel (in_valid_i/in_ready_o): one string byte per transaction on
// ch_i, with final_byte_i set on the last byte of the string.
// Output channel (out_valid_o/out_ready_i): at most one result per byte:
// a finished option (start, name and value lengths, name match), an end
// with an open quote, or a parse error; is_last_o marks the result of the
// final byte. Bytes that close nothing give no result.
// Configuration channel (cfg_valid_i/cfg_ready_o, always ready): index 0
// and 1 load target name bytes 0-7 and 8-15, index 2 the target length.
// Write it only while no bytes are in flight.
// Path: an accepted byte sits in the input register, and the parse step then
// loads the result register from it once the result side is free.
// Throughput is one byte per cycle while the result side does not stall; the
// per-byte state update is a loop through the parse state registers.
// Reset clears the parse state, the target and the valid flags of both
// pipeline registers; the block is ready right out of reset.
// A stalled receiver holds the result register; one more byte is taken
// into the input register and then in_ready_o drops until the result moves.
module option_list_tokenizer_matcher_top
  import oltm_pkg::*;
#(
  parameter int MAX_LEN      = MAX_LEN_DEF,
  parameter int TARGET_BYTES = TARGET_BYTES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [CH_W-1:0]           ch_i,
  input  logic                      final_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [KIND_W-1:0]         kind_o,
  output logic [OPTION_START_W-1:0] option_start_o,
  output logic [NAME_LENGTH_W-1:0]  name_length_o,
  output logic                      has_value_o,
  output logic [VALUE_LENGTH_W-1:0] value_length_o,
  output logic                      name_match_o,
  output logic                      is_last_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i
);

  logic [TARGET_BYTES-1:0][CH_W-1:0] target_q;
  logic [TLEN_W-1:0]                 tlen_q;
  in_item_t                          in_item, held_item;
  logic                              held_valid, take;
  result_t                           result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      tlen_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      for (int b = 0; b < TARGET_BYTES; b++) begin
        if ((b < BYTES_PER_WORD) && (cfg_index_i == REG_TARGET_LOW)) begin
          target_q[b] <= cfg_data_i[(b % BYTES_PER_WORD)*CH_W +: CH_W];
        end
        if ((b >= BYTES_PER_WORD) && (cfg_index_i == REG_TARGET_HIGH)) begin
          target_q[b] <= cfg_data_i[(b % BYTES_PER_WORD)*CH_W +: CH_W];
        end
      end
      if (cfg_index_i == REG_TARGET_LEN) begin
        tlen_q <= cfg_data_i[TLEN_W-1:0];
      end
    end
  end

  assign in_item.ch         = ch_i;
  assign in_item.final_byte = final_byte_i;

  oltm_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .item_i    (in_item),
    .valid_o   (held_valid),
    .item_o    (held_item),
    .take_i    (take)
  );

  oltm_core #(
    .MAX_LEN     (MAX_LEN),
    .TARGET_BYTES(TARGET_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (held_valid),
    .item_i     (held_item),
    .take_o     (take),
    .target_i   (target_q),
    .tlen_i     (tlen_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .result_o   (result)
  );

  assign kind_o         = result.kind;
  assign option_start_o = result.option_start;
  assign name_length_o  = result.name_length;
  assign has_value_o    = result.has_value;
  assign value_length_o = result.value_length;
  assign name_match_o   = result.name_match;
  assign is_last_o      = result.is_last;

`ifndef ASSERT_OFF
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while the result side was free");

  a_non_option_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o != KIND_OPTION)) |->
      (option_start_o == '0 && name_length_o == '0 && !has_value_o &&
       value_length_o == '0 && !name_match_o))
    else $error("end or error result carries option fields");

  a_no_value_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_value_o) |-> (value_length_o == '0))
    else $error("value length without a separator");
`endif

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import oltm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      in_valid_i   = 1'b0;
  logic [CH_W-1:0]           ch_i         = '0;
  logic                      final_byte_i = 1'b0;
  logic                      out_ready_i  = 1'b0;
  logic                      cfg_valid_i  = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0]     cfg_data_i   = '0;
  logic                      in_ready_o;
  logic                      out_valid_o;
  logic [KIND_W-1:0]         kind_o;
  logic [OPTION_START_W-1:0] option_start_o;
  logic [NAME_LENGTH_W-1:0]  name_length_o;
  logic                      has_value_o;
  logic [VALUE_LENGTH_W-1:0] value_length_o;
  logic                      name_match_o;
  logic                      is_last_o;
  logic                      cfg_ready_o;

  option_list_tokenizer_matcher_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .ch_i          (ch_i),
    .final_byte_i  (final_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .option_start_o(option_start_o),
    .name_length_o (name_length_o),
    .has_value_o   (has_value_o),
    .value_length_o(value_length_o),
    .name_match_o  (name_match_o),
    .is_last_o     (is_last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  in_item_t string_bytes_q[$];
  result_t  pending_results[$];
  int       err_cnt     = 0;
  int       bytes_taken = 0;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;
  logic     rx_hold     = 1'b0;

  // Tokenizer state and target name as the block should hold them.
  logic [63:0] want_lo  = '0;
  logic [63:0] want_hi  = '0;
  logic [4:0]  want_len = '0;
  int          tok_pos, tok_start, tok_sep;
  logic        in_option, in_quote, sep_seen, name_differs, skip_rest;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [7:0] target_byte(input int idx);
    if (idx < 8) return want_lo[8*idx +: 8];
    return want_hi[8*(idx-8) +: 8];
  endfunction

  function automatic void clear_parse();
    tok_pos      = 0;
    tok_start    = 0;
    tok_sep      = 0;
    in_option    = 1'b0;
    in_quote     = 1'b0;
    sep_seen     = 1'b0;
    name_differs = 1'b0;
    skip_rest    = 1'b0;
  endfunction

  function automatic void check_name_byte(input logic [7:0] c, input int idx);
    if (idx >= TARGET_BYTES_DEF || idx >= want_len || target_byte(idx) != c)
      name_differs = 1'b1;
  endfunction

  function automatic void parse_error(input logic last, output result_t r);
    if (last) clear_parse();
    else skip_rest = 1'b1;
    r         = '0;
    r.kind    = KIND_ERROR;
    r.is_last = last;
  endfunction

  // Advance the tokenizer by one byte; return 1 when the byte closes something.
  function automatic bit tokenize_byte(input logic [7:0] c, input logic last,
                                       output result_t r);
    int   p, stop, nlen, vlen;
    logic comma, sep;
    r = '0;
    p = tok_pos;
    if (skip_rest) begin
      if (last) begin
        parse_error(1'b1, r);
        return 1;
      end
      return 0;
    end
    if (p >= MAX_LEN_DEF) begin
      parse_error(last, r);
      return 1;
    end
    if (!in_option) begin
      in_option    = 1'b1;
      tok_start    = p;
      sep_seen     = 1'b0;
      name_differs = 1'b0;
      in_quote     = 1'b0;
    end
    if (c == QUOTE_CH) in_quote = !in_quote;
    if (in_quote) begin
      if (!sep_seen) check_name_byte(c, p - tok_start);
      tok_pos = p + 1;
      if (last) begin
        clear_parse();
        r.kind    = KIND_END;
        r.is_last = 1'b1;
        return 1;
      end
      return 0;
    end
    comma = (c == COMMA_CH);
    sep   = !sep_seen && c == EQUALS_CH;
    if (comma && p == tok_start) begin
      parse_error(last, r);
      return 1;
    end
    if (!sep_seen && !sep && !comma) check_name_byte(c, p - tok_start);
    if (sep) begin
      sep_seen = 1'b1;
      tok_sep  = p;
    end
    tok_pos = p + 1;
    if (!(comma || last)) return 0;
    stop = comma ? p : p + 1;
    if (sep_seen) begin
      nlen = tok_sep - tok_start;
      vlen = stop - tok_sep - 1;
    end else begin
      nlen = stop - tok_start;
      vlen = 0;
    end
    r.kind         = KIND_OPTION;
    r.option_start = tok_start[OPTION_START_W-1:0];
    r.name_length  = nlen[NAME_LENGTH_W-1:0];
    r.has_value    = sep_seen;
    r.value_length = vlen[VALUE_LENGTH_W-1:0];
    r.name_match   = !name_differs && nlen == want_len;
    r.is_last      = last;
    in_option    = 1'b0;
    sep_seen     = 1'b0;
    name_differs = 1'b0;
    if (last) clear_parse();
    return 1;
  endfunction

  task automatic compare_field(input string fld, input logic [12:0] exp_v,
                               input logic [12:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Byte driver: hold the transaction until taken, then maybe idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      ch_i         <= '0;
      final_byte_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (string_bytes_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_valid_i <= 1'b1;
        {ch_i, final_byte_i} <= string_bytes_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= !rx_hold && $urandom_range(0, 99) >= rx_idle_pct;
  end

  always @(posedge clk_i) begin
    result_t want, got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_TARGET_LOW:  want_lo  = cfg_data_i;
          REG_TARGET_HIGH: want_hi  = cfg_data_i;
          REG_TARGET_LEN:  want_len = cfg_data_i[TLEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        bytes_taken++;
        if (tokenize_byte(ch_i, final_byte_i, want)) pending_results.push_back(want);
      end
      if (out_valid_o && out_ready_i) begin
        got.kind         = kind_e'(kind_o);
        got.option_start = option_start_o;
        got.name_length  = name_length_o;
        got.has_value    = has_value_o;
        got.value_length = value_length_o;
        got.name_match   = name_match_o;
        got.is_last      = is_last_o;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d start %0d last %0d",
                   $time, kind_o, option_start_o, is_last_o);
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          compare_field("kind", want.kind, got.kind);
          compare_field("option_start", want.option_start, got.option_start);
          compare_field("name_length", want.name_length, got.name_length);
          compare_field("has_value", want.has_value, got.has_value);
          compare_field("value_length", want.value_length, got.value_length);
          compare_field("name_match", want.name_match, got.name_match);
          compare_field("is_last", want.is_last, got.is_last);
        end
      end
    end
  end

  // Hold off the receiver long enough for the block to stall its input.
  initial begin
    while (bytes_taken < 120) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (150) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == QUOTE_CH || b == EQUALS_CH || b == COMMA_CH) b ^= 8'h80;
    return b;
  endfunction

  function automatic logic [63:0] plain_word();
    logic [63:0] w;
    for (int i = 0; i < 8; i++) w[8*i +: 8] = plain_byte();
    return w;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return COMMA_CH;
      3:       return EQUALS_CH;
      4:       return QUOTE_CH;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] value_byte();
    case ($urandom_range(0, 19))
      0:       return EQUALS_CH;
      1:       return QUOTE_CH;
      default: return plain_byte();
    endcase
  endfunction

  task automatic send_string(input logic [7:0] s[$]);
    for (int i = 0; i < s.size(); i++)
      string_bytes_q.push_back(in_item_t'{ch: s[i], final_byte: i == s.size() - 1});
  endtask

  task automatic send_text(input string t);
    logic [7:0] s[$];
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
    send_string(s);
  endtask

  task automatic add_name(ref logic [7:0] s[$]);
    int sel, n;
    sel = $urandom_range(0, 9);
    n   = (want_len > 16) ? 16 : want_len;
    if (sel < 4) begin
      for (int i = 0; i < n; i++) s.push_back(target_byte(i));
    end else if (sel == 4) begin
      for (int i = 0; i < n; i++) s.push_back(target_byte(i));
      s.push_back(plain_byte());
    end else if (sel == 5) begin
      for (int i = 0; i < n; i++) s.push_back(i == n - 1 ? plain_byte() : target_byte(i));
    end else if (sel == 6) begin
      s.push_back(QUOTE_CH);
      repeat ($urandom_range(1, 4))
        s.push_back($urandom_range(0, 2) == 0 ? plain_byte() :
                    ($urandom_range(0, 1) ? COMMA_CH : EQUALS_CH));
      s.push_back(QUOTE_CH);
    end else if (sel != 7) begin
      repeat ($urandom_range(1, 6)) s.push_back(plain_byte());
    end
  endtask

  // Mostly well-formed option lists, some noise.
  task automatic random_string(output int n);
    logic [7:0] s[$];
    int         opts;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 8)) s.push_back(noise_byte());
    end else begin
      opts = $urandom_range(1, 4);
      for (int k = 0; k < opts; k++) begin
        if (k != 0) s.push_back(COMMA_CH);
        add_name(s);
        if ($urandom_range(0, 9) < 6) begin
          s.push_back(EQUALS_CH);
          repeat ($urandom_range(0, 5)) s.push_back(value_byte());
        end
      end
      if ($urandom_range(0, 9) == 0) s.push_back(COMMA_CH);
    end
    n = s.size();
    send_string(s);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait out every outstanding result plus the pipeline of result-less bytes.
  task automatic drain();
    while (string_bytes_q.size() != 0 || in_valid_i || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic random_phase(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [63:0] len_data);
    int sent, n;
    drain();
    write_reg(REG_TARGET_LOW, lo);
    write_reg(REG_TARGET_HIGH, hi);
    write_reg(REG_TARGET_LEN, len_data);
    drain();
    sent = 0;
    while (sent < 135) begin
      random_string(n);
      sent += n;
    end
  endtask

  initial begin
    logic [7:0] bq[$];
    clear_parse();
    tx_idle_pct = 17;
    rx_idle_pct = 62;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Target "ab"; upper bits of the length write must be dropped.
    write_reg(REG_TARGET_LOW, 64'h6261);
    write_reg(REG_TARGET_HIGH, 64'h0);
    write_reg(REG_TARGET_LEN, 64'hFFFF_FFFF_FFFF_FFE2);
    write_reg(REG_SPARE, {$urandom, $urandom});
    drain();
    send_text("ab=c,d");
    send_text(",");
    send_text(",x");
    send_text("\"a");
    send_text("a,");
    send_text("=");
    send_text("\"a,b\"=1");
    bq = {8'h00};
    send_string(bq);
    bq = {8'hFF};
    send_string(bq);
    send_text("a,,b");
    send_text("ab");

    random_phase(plain_word(), plain_word(), 64'd3);
    random_phase(plain_word(), plain_word(), 64'd0);

    tx_idle_pct = 62;
    rx_idle_pct = 17;
    random_phase(plain_word(), plain_word(), 64'd16);
    random_phase({64{1'b1}}, {64{1'b1}}, 64'd17);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase({64{1'b1}}, {64{1'b1}}, 64'd31);
    drain();
    write_reg(REG_SPARE, {$urandom, $urandom});
    random_phase(64'h0, 64'h0, 64'd8);

    drain();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
